### sv/assert_macros.svh
// Assertion macros used by the frame engine module.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### sv/lmfe_pkg.sv
// Package for the LED matrix frame engine: command codes, states, select code.
// No dependencies.
package lmfe_pkg;
  typedef enum logic [3:0] {
    ACT_CLEAR = 4'd0, ACT_WPOINT = 4'd1, ACT_RPOINT = 4'd2, ACT_WROW = 4'd3,
    ACT_ORROW = 4'd4, ACT_MOVE = 4'd5, ACT_LINE = 4'd6, ACT_LINEC = 4'd7,
    ACT_SCAN = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_RMW, ST_READ, ST_SCAN, ST_LSTEP, ST_LWAIT
  } state_t;

  localparam logic [7:0] SEL_ROW0 = 8'd160;

  function automatic logic [7:0] select_for(input logic [4:0] j);
    logic [7:0] r;
    if (j == 5'd0) r = SEL_ROW0;
    else if (j < 5'd16) r = {3'd0, j};
    else r = {j[3:0] - 4'd15, 4'd0};
    return r;
  endfunction
endpackage

### sv/lmfe_store.sv
// Frame store memory: one write port, one registered read port.
// Depends on nothing beyond its parameters.
module lmfe_store #(
  parameter int DEPTH = 25,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/led_matrix_frame_engine.sv
// LED matrix frame engine. Command set on in_ ports, results strobed on out_.
// Uses lmfe_pkg, lmfe_store and assert_macros.svh.
// Busy stays high while a command works, and after reset while the store is
// cleared one row per cycle. A clear writes one row per cycle; a point or row
// write reads the row, then modifies and writes it back; a scan puts out one
// row word per cycle from the memory read port; a line reads, then writes back
// the row for each pixel walked. Move, unused codes, skipped lines and
// out-of-range writes never raise busy.
// Results cannot be stalled.
`include "assert_macros.svh"
module led_matrix_frame_engine import lmfe_pkg::*; #(
  parameter int MATRIX_SIZE = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        in_action,
  input  logic [4:0]        in_pixel_column,
  input  logic [4:0]        in_row_index,
  input  logic              in_point_value,
  input  logic [31:0]       in_row_bits,
  input  logic signed [5:0] in_x_start,
  input  logic signed [5:0] in_y_start,
  input  logic signed [5:0] in_x_end,
  input  logic signed [5:0] in_y_end,
  output logic              out_strobe,
  output logic              out_result_kind,
  output logic              out_point_state,
  output logic [7:0]        out_select_code,
  output logic [31:0]       out_row_data,
  output logic              out_is_last
);
  localparam int AW = 5;
  localparam logic signed [7:0] MS = 8'(MATRIX_SIZE);

  state_t state_r, state_nxt;
  logic [3:0]  act_r;
  logic [4:0]  col_r, row_r;
  logic        val_r;
  logic [31:0] bits_r;
  logic [4:0]  idx_r, idx_nxt;
  logic signed [5:0] cur_c_r, cur_r_r;
  // line walker, 8-bit signed
  logic signed [7:0] a_r, b_r, cnt_r, dmaj_r, dmin_r, inc_r;
  logic signed [7:0] a_nxt, b_nxt, cnt_nxt;
  logic        ymaj_r;
  logic [6:0]  left_r;

  logic        we;
  logic [4:0]  waddr, raddr;
  logic [31:0] wdata, rdata;

  lmfe_store #(.DEPTH(MATRIX_SIZE), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);

  // line setup from inputs
  logic signed [7:0] x1, y1, x2, y2, ddx, ddy;
  logic              ymaj, skip;
  always_comb begin
    x1 = (in_action == ACT_LINEC) ? 8'(cur_c_r) : 8'(in_x_start);
    y1 = (in_action == ACT_LINEC) ? 8'(cur_r_r) : 8'(in_y_start);
    x2 = 8'(in_x_end);
    y2 = 8'(in_y_end);
    ddx = (x2 > x1) ? x2 - x1 : x1 - x2;
    ddy = (y2 > y1) ? y2 - y1 : y1 - y2;
    ymaj = !(ddx > ddy);
    skip = (x1 >= MS && x2 >= MS) || (y1 >= MS && y2 >= MS);
  end

  // current pixel of walker after its step
  logic signed [7:0] pa, pb;
  logic              pin;
  always_comb begin
    cnt_nxt = cnt_r + dmin_r;
    pa = a_r;
    pb = b_r;
    if (cnt_nxt > dmaj_r) begin
      cnt_nxt = cnt_nxt - dmaj_r;
      if (ymaj_r) pa = a_r + inc_r;
      else pb = b_r + inc_r;
    end
    pin = pa >= 0 && pa < MS && pb >= 0 && pb < MS && pa < 8'sd32;
    a_nxt = ymaj_r ? pa : pa + 8'sd1;
    b_nxt = ymaj_r ? pb + 8'sd1 : pb;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    we = 1'b0;
    waddr = row_r;
    wdata = rdata;
    raddr = in_row_index;
    out_strobe = 1'b0;
    out_result_kind = 1'b0;
    out_point_state = 1'b0;
    out_select_code = 8'd0;
    out_row_data = 32'd0;
    out_is_last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          case (in_action) inside
            ACT_CLEAR: state_nxt = ST_CLEAR;
            ACT_WPOINT, ACT_WROW, ACT_ORROW:
              if ({1'b0, in_row_index} < 6'(MATRIX_SIZE)) state_nxt = ST_RMW;
            ACT_RPOINT: state_nxt = ST_READ;
            ACT_SCAN: begin
              raddr = '0;
              idx_nxt = 5'd1;
              state_nxt = ST_SCAN;
            end
            ACT_LINE, ACT_LINEC: if (!skip) state_nxt = ST_LSTEP;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        waddr = idx_r;
        wdata = '0;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'(MATRIX_SIZE - 1)) state_nxt = ST_IDLE;
      end
      ST_RMW: begin
        we = 1'b1;
        case (act_r)
          ACT_WPOINT: wdata = val_r ? (rdata | (32'd1 << col_r))
                                    : (rdata & ~(32'd1 << col_r));
          ACT_WROW: wdata = bits_r;
          default: wdata = rdata | bits_r;
        endcase
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        out_strobe = 1'b1;
        out_point_state = ({1'b0, row_r} < 6'(MATRIX_SIZE)) ? rdata[col_r] : 1'b0;
        out_is_last = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        raddr = idx_r;
        out_strobe = 1'b1;
        out_result_kind = 1'b1;
        out_select_code = select_for(idx_r - 5'd1);
        out_row_data = rdata;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'(MATRIX_SIZE)) begin
          out_is_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LSTEP: begin
        raddr = pb[4:0];
        state_nxt = ST_LWAIT;
      end
      ST_LWAIT: begin
        raddr = pb[4:0];
        we = pin;
        waddr = pb[4:0];
        wdata = rdata | (32'd1 << pa[4:0]);
        if (left_r == 7'd0 || (ymaj_r ? b_nxt >= MS : a_nxt >= MS))
          state_nxt = ST_IDLE;
        else state_nxt = ST_LSTEP;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r <= '0;
      cur_c_r <= '0;
      cur_r_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      if (accept && (in_action == ACT_MOVE || in_action == ACT_LINEC)) begin
        cur_c_r <= in_x_end;
        cur_r_r <= in_y_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      col_r <= in_pixel_column;
      row_r <= in_row_index;
      val_r <= in_point_value;
      bits_r <= in_row_bits;
      ymaj_r <= ymaj;
      cnt_r <= '0;
      dmaj_r <= ymaj ? ddy : ddx;
      dmin_r <= ymaj ? ddx : ddy;
      left_r <= ymaj ? ddy[6:0] : ddx[6:0];
      if (ymaj) begin
        a_r <= (y2 > y1) ? x1 : x2;
        b_r <= (y2 > y1) ? y1 : y2;
        inc_r <= (((y2 > y1) ? x2 : x1) > ((y2 > y1) ? x1 : x2)) ? 8'sd1 : -8'sd1;
      end else begin
        a_r <= (x2 > x1) ? x1 : x2;
        b_r <= (x2 > x1) ? y1 : y2;
        inc_r <= (((x2 > x1) ? y2 : y1) > ((x2 > x1) ? y1 : y2)) ? 8'sd1 : -8'sd1;
      end
    end else if (state_r == ST_LWAIT) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      cnt_r <= cnt_nxt;
      left_r <= left_r - 7'd1;
    end
  end

  `ASSERT_IMPLIES(a_strobe_busy, clk, rst_n, out_strobe, busy)
  `ASSERT_NEXT(a_last_idle, clk, rst_n, out_strobe && out_is_last, state_r == ST_IDLE)
  `ASSERT_IMPLIES(a_no_write_idle, clk, rst_n, state_r == ST_IDLE, !we)
endmodule
